@@ design/full_linear_convolution_unit_macros.svh @@
// Assertion macros shared by the assertions of the convolution unit's checker.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef FULL_LINEAR_CONVOLUTION_UNIT_MACROS_SVH
`define FULL_LINEAR_CONVOLUTION_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FLCU_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define FLCU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/flcu_pkg.sv @@
// Shared types and constants of the full linear convolution unit.
// No dependencies; every other design file but the macro header refers to it by scoped names.
`timescale 1ns / 1ps

package flcu_pkg;

	// Fixed widths of the result, the configuration register and the tap index field.
	localparam int OUT_BITS  = 36;
	localparam int CFG_BITS  = 5;
	localparam int IDX_BITS  = 4;

	// Defaults of the top-level parameters.
	localparam int MAX_TAPS_DEF    = 16;
	localparam int SAMPLE_BITS_DEF = 16;

	// Tap count after reset.
	localparam logic [CFG_BITS-1:0] TAP_COUNT_RESET = 5'd1;

	// Item command codes.
	typedef enum logic {
		CMD_TAP    = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	// Control that travels with each output through the pipeline.
	typedef struct packed {
		logic valid;
		logic eos;
	} ctl_t;

endpackage

@@ design/flcu_front.sv @@
// Front end: kernel coefficient store, sample delay line and the tail flush sequencer.
// Depends on flcu_pkg.
`timescale 1ns / 1ps

module flcu_front #(
	parameter int MAX_TAPS    = flcu_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = flcu_pkg::SAMPLE_BITS_DEF,
	localparam int IW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
	localparam int NW   = $clog2(MAX_TAPS + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic                            adv,
	input  logic                            command,
	input  logic [flcu_pkg::IDX_BITS-1:0]   tap_index,
	input  logic signed [SAMPLE_BITS-1:0]   value,
	input  logic                            last_sample,
	input  logic [flcu_pkg::CFG_BITS-1:0]   tap_count,
	output logic                            flush_busy,
	output logic [NW-1:0]                   n_taps,
	output flcu_pkg::ctl_t                  ctl_s1,
	output logic signed [SAMPLE_BITS-1:0]   hist_q [MAX_TAPS],
	output logic signed [SAMPLE_BITS-1:0]   kernel_q [MAX_TAPS]
);

	localparam int CMPW = (NW > flcu_pkg::CFG_BITS) ? NW : flcu_pkg::CFG_BITS;

	logic [CMPW-1:0]              cnt_ext;
	logic                         single_tap;
	logic                         is_sample;
	logic                         sample_in;
	logic                         flush_step;
	logic                         shift;
	logic                         shift_eos;
	logic signed [SAMPLE_BITS-1:0] shift_val;
	logic [IW-1:0]                flush_cnt_q;
	logic                         clr_q;

	// Zero means one tap, and anything past the store means all of it.
	assign cnt_ext    = CMPW'(tap_count);
	assign n_taps     = (cnt_ext == '0) ? NW'(1) :
	                    (cnt_ext > CMPW'(MAX_TAPS)) ? NW'(MAX_TAPS) : NW'(cnt_ext);
	assign single_tap = (n_taps == NW'(1));

	assign is_sample  = (command == flcu_pkg::CMD_SAMPLE);
	assign sample_in  = accept && is_sample;
	assign flush_busy = (flush_cnt_q != '0);
	assign flush_step = flush_busy && adv;
	assign shift      = sample_in || flush_step;
	assign shift_val  = sample_in ? value : '0;
	assign shift_eos  = sample_in ? (last_sample && single_tap) : (flush_cnt_q == IW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TAPS; i++) begin
				kernel_q[i] <= '0;
			end
		end else if (accept && !is_sample && (32'(tap_index) < MAX_TAPS)) begin
			kernel_q[IW'(tap_index)] <= value;
		end
	end

	// The window of a finished signal is dropped on the next shift.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TAPS; i++) begin
				hist_q[i] <= '0;
			end
			clr_q <= 1'b0;
		end else if (shift) begin
			hist_q[0] <= shift_val;
			for (int i = 1; i < MAX_TAPS; i++) begin
				hist_q[i] <= clr_q ? '0 : hist_q[i-1];
			end
			clr_q <= shift_eos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_cnt_q <= '0;
		end else if (sample_in && last_sample && !single_tap) begin
			flush_cnt_q <= IW'(n_taps - NW'(1));
		end else if (flush_step) begin
			flush_cnt_q <= flush_cnt_q - IW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= '{valid: shift, eos: shift_eos};
		end
	end

endmodule

@@ design/flcu_products.sv @@
// Multiplier lanes: one product per tap, masked to the taps in use, registered.
// Depends on flcu_pkg.
`timescale 1ns / 1ps

module flcu_products #(
	parameter int MAX_TAPS    = flcu_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = flcu_pkg::SAMPLE_BITS_DEF,
	localparam int NW = $clog2(MAX_TAPS + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic [NW-1:0]                   n_taps,
	input  flcu_pkg::ctl_t                  ctl_s1,
	input  logic signed [SAMPLE_BITS-1:0]   hist_q [MAX_TAPS],
	input  logic signed [SAMPLE_BITS-1:0]   kernel_q [MAX_TAPS],
	output flcu_pkg::ctl_t                  ctl_s2,
	output logic [flcu_pkg::OUT_BITS-1:0]   prod_s2 [MAX_TAPS]
);

	localparam int FW = 2 * SAMPLE_BITS;
	localparam int PW = (FW > flcu_pkg::OUT_BITS) ? FW : flcu_pkg::OUT_BITS;

	for (genvar i = 0; i < MAX_TAPS; i++) begin : g_lane
		logic signed [FW-1:0] full;
		logic signed [PW-1:0] wide;
		logic                 lane_on;

		assign full    = hist_q[i] * kernel_q[i];
		assign wide    = PW'(full);
		assign lane_on = (NW'(i) < n_taps);

		always_ff @(posedge clk) begin
			if (adv) begin
				prod_s2[i] <= lane_on ? wide[flcu_pkg::OUT_BITS-1:0] : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
		end
	end

endmodule

@@ design/flcu_sum.sv @@
// Two-level adder tree over the lane products, feeding the output register.
// Depends on flcu_pkg.
`timescale 1ns / 1ps

module flcu_sum #(
	parameter int MAX_TAPS = flcu_pkg::MAX_TAPS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv_s3,
	input  logic                            adv_out,
	input  flcu_pkg::ctl_t                  ctl_s2,
	input  logic [flcu_pkg::OUT_BITS-1:0]   prod_s2 [MAX_TAPS],
	output flcu_pkg::ctl_t                  ctl_s3,
	output flcu_pkg::ctl_t                  out_ctl_q,
	output logic [flcu_pkg::OUT_BITS-1:0]   out_value_q
);

	localparam int GROUPS = (MAX_TAPS + 3) / 4;

	logic [flcu_pkg::OUT_BITS-1:0] padded [GROUPS*4];
	logic [flcu_pkg::OUT_BITS-1:0] part   [GROUPS];
	logic [flcu_pkg::OUT_BITS-1:0] part_s3 [GROUPS];
	logic [flcu_pkg::OUT_BITS-1:0] total;

	for (genvar j = 0; j < GROUPS * 4; j++) begin : g_pad
		if (j < MAX_TAPS) begin : g_real
			assign padded[j] = prod_s2[j];
		end else begin : g_zero
			assign padded[j] = '0;
		end
	end

	// Sums wrap at the output width, as the result does.
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			part[g] = padded[4*g] + padded[4*g+1] + padded[4*g+2] + padded[4*g+3];
		end
	end

	always_comb begin
		total = '0;
		for (int g = 0; g < GROUPS; g++) begin
			total = total + part_s3[g];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			part_s3 <= part;
		end
		if (adv_out) begin
			out_value_q <= total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3    <= '0;
			out_ctl_q <= '0;
		end else begin
			if (adv_s3) begin
				ctl_s3 <= ctl_s2;
			end
			if (adv_out) begin
				out_ctl_q <= '{valid: ctl_s3.valid, eos: ctl_s3.valid && ctl_s3.eos};
			end
		end
	end

endmodule

@@ design/full_linear_convolution_unit.sv @@
// Top level of the full linear convolution unit: handshakes, tap count register, pipeline.
// Depends on flcu_pkg, flcu_front, flcu_products and flcu_sum.
//
//   Channel  | Handshake                | Payload
//   ---------+--------------------------+--------------------------------------------
//   item     | item_valid / item_stall  | command, tap_index, value, last_sample
//   result   | result_valid/result_stall| out_value, end_of_signal
//   config   | cfg_valid / cfg_ready    | cfg_data (tap_count)
//
// One item is taken per cycle while item_stall is low. A sample's result then passes
// four registers: delay line, multiplier lanes, partial sums, output register.
// After a sample flagged last, the flush sequencer shifts in n_taps-1 zeros, one per cycle
// while stage 1 advances, and holds item_stall high during that time.
// The pipeline is elastic: each stage loads when it is empty or its content moves on, so
// a waiting result does not stop items while bubbles remain upstream.
// Reset clears the kernel, the delay line, the pipeline valids and sets tap_count to one.
`timescale 1ns / 1ps

module full_linear_convolution_unit #(
	parameter int MAX_TAPS    = flcu_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = flcu_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Item channel.
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  logic                                  command,
	input  logic [flcu_pkg::IDX_BITS-1:0]         tap_index,
	input  logic signed [SAMPLE_BITS-1:0]         value,
	input  logic                                  last_sample,
	// Result channel.
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic signed [flcu_pkg::OUT_BITS-1:0]  out_value,
	output logic                                  end_of_signal,
	// Configuration channel.
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [flcu_pkg::CFG_BITS-1:0]         cfg_data
);

	localparam int NW = $clog2(MAX_TAPS + 1);

	logic [flcu_pkg::CFG_BITS-1:0] tap_count_q;

	logic                          adv_s1;
	logic                          adv_s2;
	logic                          adv_s3;
	logic                          adv_out;
	logic                          item_accept;
	logic                          flush_busy;
	logic [NW-1:0]                 n_taps;

	flcu_pkg::ctl_t                ctl_s1;
	flcu_pkg::ctl_t                ctl_s2;
	flcu_pkg::ctl_t                ctl_s3;
	flcu_pkg::ctl_t                out_ctl_q;

	logic signed [SAMPLE_BITS-1:0] hist_q   [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] kernel_q [MAX_TAPS];
	logic [flcu_pkg::OUT_BITS-1:0] prod_s2  [MAX_TAPS];
	logic [flcu_pkg::OUT_BITS-1:0] out_value_q;

	// The tap count register takes a write in any cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= flcu_pkg::TAP_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tap_count_q <= cfg_data;
		end
	end

	// A stage loads when it is empty or when its content moves on at this edge.
	assign adv_out = !out_ctl_q.valid || !result_stall;
	assign adv_s3  = !ctl_s3.valid || adv_out;
	assign adv_s2  = !ctl_s2.valid || adv_s3;
	assign adv_s1  = !ctl_s1.valid || adv_s2;

	// Tap writes wait with samples, so a held window is never multiplied by a newer kernel.
	assign item_stall  = !adv_s1 || flush_busy;
	assign item_accept = item_valid && !item_stall;

	flcu_front #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (item_accept),
		.adv         (adv_s1),
		.command     (command),
		.tap_index   (tap_index),
		.value       (value),
		.last_sample (last_sample),
		.tap_count   (tap_count_q),
		.flush_busy  (flush_busy),
		.n_taps      (n_taps),
		.ctl_s1      (ctl_s1),
		.hist_q      (hist_q),
		.kernel_q    (kernel_q)
	);

	flcu_products #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_products (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv_s2),
		.n_taps   (n_taps),
		.ctl_s1   (ctl_s1),
		.hist_q   (hist_q),
		.kernel_q (kernel_q),
		.ctl_s2   (ctl_s2),
		.prod_s2  (prod_s2)
	);

	flcu_sum #(
		.MAX_TAPS (MAX_TAPS)
	) u_sum (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv_s3      (adv_s3),
		.adv_out     (adv_out),
		.ctl_s2      (ctl_s2),
		.prod_s2     (prod_s2),
		.ctl_s3      (ctl_s3),
		.out_ctl_q   (out_ctl_q),
		.out_value_q (out_value_q)
	);

	assign result_valid  = out_ctl_q.valid;
	assign end_of_signal = out_ctl_q.eos;
	assign out_value     = $signed(out_value_q);

endmodule

@@ design/flcu_checker.sv @@
// Port-level checker of the convolution unit, bound to the top level.
// Depends on flcu_pkg and full_linear_convolution_unit_macros.svh.
`timescale 1ns / 1ps
`include "full_linear_convolution_unit_macros.svh"

module flcu_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 item_valid,
	input logic                                 item_stall,
	input logic                                 command,
	input logic                                 result_valid,
	input logic                                 result_stall,
	input logic signed [flcu_pkg::OUT_BITS-1:0] out_value,
	input logic                                 end_of_signal
);

	logic sample_xfer;

	assign sample_xfer = item_valid && !item_stall && (command == flcu_pkg::CMD_SAMPLE);

	// A result held by the receiver keeps its value and flag.
	`FLCU_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(out_value) && $stable(end_of_signal), "result changed while stalled")

	// With result_stall low as a sample moves through the stages, its result reaches the output.
	`FLCU_ASSERT_NEXT(a_sample_latency, sample_xfer ##1 !result_stall ##1 !result_stall ##1 !result_stall, result_valid, "sample result missing after four cycles")

	// The end flag only rides on a real result.
	`FLCU_ASSERT_IMPL(a_eos_valid, end_of_signal, result_valid, "end_of_signal without a result")

endmodule

bind full_linear_convolution_unit flcu_checker u_flcu_checker (.*);
